@@ hw/rtl/phi_z_wedge_membership_test_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Phi/z wedge membership test: assertion macros
// Shared property shapes for the port checker.
// ---------------------------------------------------------------------------
`ifndef PHI_Z_WEDGE_MEMBERSHIP_TEST_UNIT_DEFINES_SVH
`define PHI_Z_WEDGE_MEMBERSHIP_TEST_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define PWZM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwzm port check failed");

// next-cycle implication, off during reset
`define PWZM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwzm port check failed");

`endif

@@ hw/rtl/pwzm_pkg.sv @@
// ---------------------------------------------------------------------------
// Phi/z wedge membership test: package
// Widths, words, register map and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package pwzm_pkg;

  localparam int COORD_W          = 24;
  localparam int ANGLE_W          = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_W         = COORD_W + 3;
  localparam int APB_ADDR_W       = 5;
  localparam int APB_DATA_W       = 32;
  localparam int REG_IDX_W        = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PHI_CENTER     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PHI_HALF_WIDTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_SLOPE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_OFFSET    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_SLOPE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_OFFSET   = 3'd5;

  localparam logic [ANGLE_W-1:0] HALF_WIDTH_RST = ANGLE_W'(1) << (ANGLE_W - 1);
  localparam logic [30:0]        CORDIC_GAIN    = 31'd1304065748;
  localparam int                 RADIUS_MIN_RAW = 25;

  typedef struct packed {
    logic                       operation;
    logic signed [COORD_W-1:0]  x_or_r;
    logic signed [COORD_W-1:0]  y_coord;
    logic signed [ANGLE_W-1:0]  phi_angle;
    logic signed [COORD_W-1:0]  z_coord;
  } in_t;

  typedef struct packed {
    logic inside_res;
    logic radius_too_small;
  } out_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] phi_center;
    logic [ANGLE_W-1:0]        phi_half_width;
    logic signed [31:0]        left_slope;
    logic signed [31:0]        left_offset;
    logic signed [31:0]        right_slope;
    logic signed [31:0]        right_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [31:0]                acc;
  } vec_t;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] x_or_r;
    logic [ANGLE_W-1:0]        phi;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [1:0] {
    LINE_BOTH_POS,
    LINE_LEFT_NEG,
    LINE_OTHER
  } line_mode_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pwzm_regs.sv @@
// ---------------------------------------------------------------------------
// Phi/z wedge membership test: configuration registers
// APB-style register bank for wedge centre, half width and the two lines.
// ---------------------------------------------------------------------------
`default_nettype none

module pwzm_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pwzm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pwzm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pwzm_pkg::APB_DATA_W-1:0] prdata,
  output pwzm_pkg::cfg_t                       cfg
);
  import pwzm_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phi_center     <= '0;
      cfg.phi_half_width <= HALF_WIDTH_RST;
      cfg.left_slope     <= '0;
      cfg.left_offset    <= '0;
      cfg.right_slope    <= '0;
      cfg.right_offset   <= '0;
    end else if (wr) begin
      case (idx)
        REG_PHI_CENTER:     cfg.phi_center     <= pwdata[ANGLE_W-1:0];
        REG_PHI_HALF_WIDTH: cfg.phi_half_width <= pwdata[ANGLE_W-1:0];
        REG_LEFT_SLOPE:     cfg.left_slope     <= pwdata;
        REG_LEFT_OFFSET:    cfg.left_offset    <= pwdata;
        REG_RIGHT_SLOPE:    cfg.right_slope    <= pwdata;
        REG_RIGHT_OFFSET:   cfg.right_offset   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PHI_CENTER:     prdata = APB_DATA_W'(unsigned'(cfg.phi_center));
      REG_PHI_HALF_WIDTH: prdata = APB_DATA_W'(cfg.phi_half_width);
      REG_LEFT_SLOPE:     prdata = cfg.left_slope;
      REG_LEFT_OFFSET:    prdata = cfg.left_offset;
      REG_RIGHT_SLOPE:    prdata = cfg.right_slope;
      REG_RIGHT_OFFSET:   prdata = cfg.right_offset;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/pwzm_cordic_stage.sv @@
// ---------------------------------------------------------------------------
// Phi/z wedge membership test: CORDIC stage
// One vectoring iteration with its valid bit and the carried point.
// ---------------------------------------------------------------------------
`default_nettype none

module pwzm_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic             in_valid,
  input  wire pwzm_pkg::vec_t   in_vec,
  input  wire pwzm_pkg::point_t in_pt,
  output logic                  out_valid,
  output pwzm_pkg::vec_t        out_vec,
  output pwzm_pkg::point_t      out_pt
);
  import pwzm_pkg::*;

  localparam logic [4:0]  IDX  = 5'(STEP);
  localparam logic [31:0] ATAN = atan_turn(IDX);

  vec_t                       vec_next;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;

  always_comb begin
    dx = in_vec.y >>> STEP;
    dy = in_vec.x >>> STEP;
    if (in_vec.y[CORDIC_W-1]) begin
      vec_next.x   = in_vec.x - dx;
      vec_next.y   = in_vec.y + dy;
      vec_next.acc = in_vec.acc - ATAN;
    end else begin
      vec_next.x   = in_vec.x + dx;
      vec_next.y   = in_vec.y - dy;
      vec_next.acc = in_vec.acc + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_vec <= vec_next;
      out_pt  <= in_pt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/phi_z_wedge_membership_test_unit.sv @@
// ---------------------------------------------------------------------------
// Phi/z wedge membership test
// Tells whether a hit point lies inside a phi/z detector wedge.
// ---------------------------------------------------------------------------
// Usage:
//   hit channel (hit_valid, hit_stall, hit) carries one point per word, either
//   cylindrical r/phi/z or Cartesian x/y/z (operation selects). res channel
//   (res_valid, res_stall, res) returns inside_res and radius_too_small, one
//   word per point, in order.
//   Throughput is one point per clock while res is not stalled; the path
//   is one input stage, one CORDIC iteration per stage, then gain multiply,
//   line adds and compare. Cylindrical points ride the same stages, so
//   order is kept. Stalling res holds the result word; bubbles in the pipe
//   still fill, and hit_stall rises only once every stage holds a point.
//   Reset clears all valid bits and loads the register defaults (centre 0,
//   half width a half turn, slopes and offsets 0). Registers are written
//   through the APB port; the user must write them only while the pipe is
//   empty, which the block itself does not enforce.
// ---------------------------------------------------------------------------
`default_nettype none

module phi_z_wedge_membership_test_unit #(
  parameter int CORDIC_STEPS = pwzm_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            hit_valid,
  output logic                                 hit_stall,
  input  wire pwzm_pkg::in_t                   hit,
  output logic                                 res_valid,
  input  wire logic                            res_stall,
  output pwzm_pkg::out_t                       res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pwzm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pwzm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pwzm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import pwzm_pkg::*;

  localparam int N      = CORDIC_STEPS;
  localparam int ANG_SH = 32 - ANGLE_W;
  localparam int MAG_W  = CORDIC_W - 1;
  localparam int PROD_W = MAG_W + 31;
  localparam int SZ_W   = 32 + COORD_W;
  localparam int LW     = SZ_W + 2;

  cfg_t cfg;

  pwzm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic   v   [0:N];
  logic   ld  [0:N];
  vec_t   cv  [0:N];
  point_t pt  [0:N];

  logic m1_valid;
  logic m2_valid;
  logic m1_ld;
  logic m2_ld;
  logic m3_ld;

  // load chain: a stage loads when empty or when its word moves on
  assign m3_ld = !res_valid || !res_stall;
  assign m2_ld = !m2_valid || m3_ld;
  assign m1_ld = !m1_valid || m2_ld;
  assign ld[N] = !v[N] || m1_ld;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_ld
      assign ld[k] = !v[k] || ld[k+1];
    end
  endgenerate

  assign hit_stall = !ld[0];

  // input stage: quarter-turn pre-rotation for negative x
  vec_t                       s0_vec_next;
  logic signed [CORDIC_W-1:0] xin;
  logic signed [CORDIC_W-1:0] yin;

  always_comb begin
    xin = CORDIC_W'(hit.x_or_r);
    yin = CORDIC_W'(hit.y_coord);
    if (xin[CORDIC_W-1]) begin
      if (!yin[CORDIC_W-1]) begin
        s0_vec_next.x   = yin;
        s0_vec_next.y   = -xin;
        s0_vec_next.acc = 32'h40000000;
      end else begin
        s0_vec_next.x   = -yin;
        s0_vec_next.y   = xin;
        s0_vec_next.acc = 32'hC0000000;
      end
    end else begin
      s0_vec_next.x   = xin;
      s0_vec_next.y   = yin;
      s0_vec_next.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ld[0]) begin
      v[0] <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      cv[0]           <= s0_vec_next;
      pt[0].operation <= hit.operation;
      pt[0].x_or_r    <= hit.x_or_r;
      pt[0].phi       <= hit.phi_angle;
      pt[0].z         <= hit.z_coord;
    end
  end

  generate
    for (k = 1; k <= N; k++) begin : g_cordic
      pwzm_cordic_stage #(
        .STEP (k - 1)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .load      (ld[k]),
        .in_valid  (v[k-1]),
        .in_vec    (cv[k-1]),
        .in_pt     (pt[k-1]),
        .out_valid (v[k]),
        .out_vec   (cv[k]),
        .out_pt    (pt[k])
      );
    end
  endgenerate

  // M1: gain multiply, slope products, angle rounding
  logic [MAG_W-1:0]          ux;
  logic [31:0]               acc_rnd;
  logic [PROD_W-1:0]         m1_prod;
  logic signed [SZ_W-1:0]    m1_lz;
  logic signed [SZ_W-1:0]    m1_rz;
  logic [ANGLE_W-1:0]        m1_phi;
  logic                      m1_op;
  logic signed [COORD_W-1:0] m1_xr;

  assign ux      = cv[N].x[CORDIC_W-1] ? '0 : cv[N].x[MAG_W-1:0];
  assign acc_rnd = cv[N].acc + (32'd1 << (ANG_SH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (m1_ld) begin
      m1_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (m1_ld) begin
      m1_prod <= PROD_W'(ux) * PROD_W'(CORDIC_GAIN);
      m1_lz   <= SZ_W'(cfg.left_slope) * SZ_W'(pt[N].z);
      m1_rz   <= SZ_W'(cfg.right_slope) * SZ_W'(pt[N].z);
      m1_phi  <= pt[N].operation ? acc_rnd[31:ANG_SH] : pt[N].phi;
      m1_op   <= pt[N].operation;
      m1_xr   <= pt[N].x_or_r;
    end
  end

  // M2: radius rounding, line values, phi window
  logic [PROD_W-1:0]          rsum;
  logic [ANGLE_W-1:0]         dphi;
  logic signed [ANGLE_W:0]    dext;
  logic [ANGLE_W:0]           dabs;
  line_mode_t                 mode_next;
  logic signed [CORDIC_W-1:0] m2_r;
  logic signed [LW-1:0]       m2_lv;
  logic signed [LW-1:0]       m2_rv;
  logic                       m2_phi_ok;
  line_mode_t                 m2_mode;

  assign rsum = m1_prod + (PROD_W'(1) << 30);
  assign dphi = m1_phi - cfg.phi_center;
  assign dext = (ANGLE_W+1)'(signed'(dphi));
  assign dabs = dext[ANGLE_W] ? unsigned'(-dext) : unsigned'(dext);

  always_comb begin
    if (!cfg.left_slope[31] && (cfg.left_slope != '0) &&
        !cfg.right_slope[31] && (cfg.right_slope != '0)) begin
      mode_next = LINE_BOTH_POS;
    end else if (cfg.left_slope[31] &&
                 !cfg.right_slope[31] && (cfg.right_slope != '0)) begin
      mode_next = LINE_LEFT_NEG;
    end else begin
      mode_next = LINE_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (m2_ld) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_ld) begin
      m2_r      <= m1_op ? signed'({1'b0, rsum[PROD_W-1:31]}) : CORDIC_W'(m1_xr);
      m2_lv     <= LW'(m1_lz) + (LW'(cfg.left_offset) <<< 16);
      m2_rv     <= LW'(m1_rz) + (LW'(cfg.right_offset) <<< 16);
      m2_phi_ok <= dabs <= {1'b0, cfg.phi_half_width};
      m2_mode   <= mode_next;
    end
  end

  // M3: radius check and line compare into the output register
  logic [CORDIC_W-1:0]  absr;
  logic signed [LW-1:0] rp;
  logic                 small_r;
  logic                 line_ok;
  out_t                 res_next;

  assign absr    = m2_r[CORDIC_W-1] ? unsigned'(-m2_r) : unsigned'(m2_r);
  assign small_r = absr <= CORDIC_W'(RADIUS_MIN_RAW);
  assign rp      = LW'(m2_r) <<< 16;

  always_comb begin
    case (m2_mode)
      LINE_BOTH_POS: line_ok = (m2_lv > rp) && (rp > m2_rv);
      LINE_LEFT_NEG: line_ok = (m2_lv < rp) && (rp > m2_rv);
      default:       line_ok = (m2_lv < rp) && (rp < m2_rv);
    endcase
    res_next.radius_too_small = small_r;
    res_next.inside_res       = !small_r && m2_phi_ok && line_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (m3_ld) begin
      res_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m3_ld) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pwzm_checker.sv @@
// ---------------------------------------------------------------------------
// Phi/z wedge membership test: port checker
// Watches the hit and res channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "phi_z_wedge_membership_test_unit_defines.svh"

module pwzm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           hit_valid,
  input wire logic           hit_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire pwzm_pkg::out_t res
);

  logic [7:0] pend;
  logic [7:0] pend_next;

  always_comb begin
    pend_next = pend + 8'(hit_valid && !hit_stall) - 8'(res_valid && !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  `PWZM_ASSERT_IMPLY(a_small_never_inside, clk, rst, res_valid, !(res.inside_res && res.radius_too_small))
  `PWZM_ASSERT_IMPLY(a_result_has_source, clk, rst, res_valid, pend != 8'd0)
  `PWZM_ASSERT_IMPLY(a_stall_only_when_full, clk, rst, hit_stall, res_valid && res_stall)
  `PWZM_ASSERT_NEXT(a_result_held, clk, rst, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind phi_z_wedge_membership_test_unit pwzm_checker u_pwzm_checker (
  .clk       (clk),
  .rst       (rst),
  .hit_valid (hit_valid),
  .hit_stall (hit_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Phi/z wedge membership test: testbench
// Streams cylindrical and Cartesian hit points through the block under random
// idling on both channels, reprograms the wedge over the APB port between
// phases, and checks every result word against a local bit-exact predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import pwzm_pkg::*;

  localparam int          IDLE_PCT    = 37;
  localparam int          DRAIN_WAIT  = CORDIC_STEPS_DEF + 3 + 20;
  localparam int          STUCK_LIMIT = 4000;
  localparam int          ITERS       = CORDIC_STEPS_DEF;
  localparam logic        OP_CYL      = 1'b0;
  localparam logic        OP_CART     = 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [31:0] ATAN_TURN [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic                  clk;
  logic                  rst;
  logic                  hit_valid;
  logic                  hit_stall;
  in_t                   hit;
  logic                  res_valid;
  logic                  res_stall;
  out_t                  res;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cfg_t        wedge;
  out_t        pending_verdicts[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned stuck_cycles;
  bit          calm;

  phi_z_wedge_membership_test_unit dut (
    .clk       (clk),
    .rst       (rst),
    .hit_valid (hit_valid),
    .hit_stall (hit_stall),
    .hit       (hit),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void cordic_polar(input longint x0, input longint y0,
                                       output longint radius,
                                       output logic [ANGLE_W-1:0] ang);
    longint      x;
    longint      y;
    longint      t;
    longint      dx;
    longint      dy;
    logic [31:0] acc;
    logic [63:0] ux;
    logic [63:0] a;
    int          i;
    x = x0;
    y = y0;
    acc = 32'h0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        acc = 32'h40000000;
      end else begin
        x = -y;
        y = t;
        acc = 32'hC0000000;
      end
    end
    for (i = 0; i < ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        acc = acc - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        acc = acc + ATAN_TURN[i];
      end
    end
    ux = (x < 0) ? 64'd0 : 64'(x);
    radius = longint'((ux * 64'd1304065748 + (64'd1 << 30)) >> 31);
    a = ({32'd0, acc} + (64'd1 << (31 - ANGLE_W))) >> (32 - ANGLE_W);
    ang = a[ANGLE_W-1:0];
  endfunction

  function automatic out_t wedge_verdict(in_t p);
    out_t                v;
    longint              r;
    longint              absr;
    longint              z;
    longint              ds;
    longint              lv;
    longint              rv;
    longint              rp;
    longint              al;
    longint              ar;
    logic [ANGLE_W-1:0]  phi;
    logic [ANGLE_W-1:0]  d;
    z = longint'($signed(p.z_coord));
    if (p.operation == OP_CART) begin
      cordic_polar(longint'($signed(p.x_or_r)), longint'($signed(p.y_coord)), r, phi);
    end else begin
      r = longint'($signed(p.x_or_r));
      phi = p.phi_angle;
    end
    absr = (r < 0) ? -r : r;
    v.radius_too_small = (absr <= RADIUS_MIN_RAW);
    v.inside_res = 1'b0;
    if (!v.radius_too_small) begin
      d = phi - wedge.phi_center;
      ds = longint'($signed(d));
      if (ds < 0) ds = -ds;
      if (ds <= longint'(wedge.phi_half_width)) begin
        al = longint'($signed(wedge.left_slope));
        ar = longint'($signed(wedge.right_slope));
        lv = al * z + longint'($signed(wedge.left_offset)) * 65536;
        rv = ar * z + longint'($signed(wedge.right_offset)) * 65536;
        rp = r * 65536;
        if (al > 0 && ar > 0) v.inside_res = (lv > rp) && (rp > rv);
        else if (al < 0 && ar > 0) v.inside_res = (lv < rp) && (rp > rv);
        else v.inside_res = (lv < rp) && (rp < rv);
      end
    end
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return COORD_W'($urandom);
    if (sel < 8) return COORD_W'($urandom_range(80)) - COORD_W'(40);
    case ($urandom_range(3))
      0: return {1'b0, {(COORD_W-1){1'b1}}};
      1: return {1'b1, {(COORD_W-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic in_t pick_point();
    in_t                p;
    logic [ANGLE_W-1:0] off;
    int unsigned        sel;
    p.operation = 1'($urandom_range(1));
    p.x_or_r = pick_coord();
    p.y_coord = pick_coord();
    p.z_coord = pick_coord();
    sel = $urandom_range(9);
    if (sel < 6) begin
      p.phi_angle = ANGLE_W'($urandom);
    end else begin
      off = wedge.phi_half_width + ANGLE_W'($urandom_range(2)) - ANGLE_W'(1);
      p.phi_angle = sel[0] ? wedge.phi_center + off : wedge.phi_center - off;
    end
    return p;
  endfunction

  function automatic logic [31:0] pick_slope(bit neg);
    logic [31:0] mag;
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom;
      default: begin
        mag = $urandom_range(32'h20000);
        return neg ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(32'h800000) - 32'h400000;
  endfunction

  function automatic cfg_t pick_wedge();
    cfg_t c;
    c.phi_center = ANGLE_W'($urandom);
    case ($urandom_range(5))
      0: c.phi_half_width = '0;
      1: c.phi_half_width = HALF_WIDTH_RST;
      2: c.phi_half_width = HALF_WIDTH_RST - 1'b1;
      default: c.phi_half_width = ANGLE_W'($urandom_range(32'h4000));
    endcase
    c.left_slope = pick_slope(1'($urandom_range(1)));
    c.right_slope = pick_slope(1'($urandom_range(1)));
    c.left_offset = pick_offset();
    c.right_offset = pick_offset();
    return c;
  endfunction

  task automatic flag_mismatch(string what, logic want, logic got);
    errors++;
    if (errors <= 10)
      $display("mismatch on word %0d, %s: expected %0b, got %0b", results_seen, what, want,
               got);
  endtask

  always @(negedge clk) begin
    res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d: %b", results_seen, res);
      end else begin
        want = pending_verdicts.pop_front();
        if (res.inside_res !== want.inside_res)
          flag_mismatch("inside_res", want.inside_res, res.inside_res);
        if (res.radius_too_small !== want.radius_too_small)
          flag_mismatch("radius_too_small", want.radius_too_small, res.radius_too_small);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((hit_valid && !hit_stall) || (res_valid && !res_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_point(in_t p);
    logic [95:0] junk;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      junk = {$urandom, $urandom, $urandom};
      hit_valid <= 1'b0;
      hit <= junk[$bits(in_t)-1:0];
      @(negedge clk);
    end
    hit_valid <= 1'b1;
    hit <= p;
    do @(posedge clk); while (hit_stall);
    pending_verdicts.push_back(wedge_verdict(p));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    hit_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PHI_CENTER:     wedge.phi_center = data[ANGLE_W-1:0];
      REG_PHI_HALF_WIDTH: wedge.phi_half_width = data[ANGLE_W-1:0];
      REG_LEFT_SLOPE:     wedge.left_slope = data;
      REG_LEFT_OFFSET:    wedge.left_offset = data;
      REG_RIGHT_SLOPE:    wedge.right_slope = data;
      REG_RIGHT_OFFSET:   wedge.right_offset = data;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_wedge(cfg_t c);
    write_reg(REG_PHI_CENTER, 32'($signed(c.phi_center)));
    write_reg(REG_PHI_HALF_WIDTH, 32'(c.phi_half_width));
    write_reg(REG_LEFT_SLOPE, c.left_slope);
    write_reg(REG_LEFT_OFFSET, c.left_offset);
    write_reg(REG_RIGHT_SLOPE, c.right_slope);
    write_reg(REG_RIGHT_OFFSET, c.right_offset);
  endtask

  function automatic in_t make_point(logic op, int xr, int yc, int phi, int zc);
    in_t p;
    p.operation = op;
    p.x_or_r = COORD_W'(xr);
    p.y_coord = COORD_W'(yc);
    p.phi_angle = ANGLE_W'(phi);
    p.z_coord = COORD_W'(zc);
    return p;
  endfunction

  task automatic test_radius_limits();
    send_point(make_point(OP_CYL, 0, 0, 0, 0));
    send_point(make_point(OP_CYL, 25, -1, 100, 0));
    send_point(make_point(OP_CYL, 26, 0, -100, 0));
    send_point(make_point(OP_CYL, -25, 0, 0, 0));
    send_point(make_point(OP_CYL, -26, 0, 32767, 0));
    send_point(make_point(OP_CYL, 8388607, 8388607, -32768, 8388607));
    send_point(make_point(OP_CYL, -8388608, -8388608, 0, -8388608));
    drain_pipe();
  endtask

  task automatic test_cartesian_quadrants();
    send_point(make_point(OP_CART, 0, 0, 0, 0));
    send_point(make_point(OP_CART, 10, 10, 0, 0));
    send_point(make_point(OP_CART, 5000, 0, 0, 0));
    send_point(make_point(OP_CART, -5000, 3000, 0, 0));
    send_point(make_point(OP_CART, -5000, -3000, 0, 0));
    send_point(make_point(OP_CART, 8388607, 8388607, 0, 0));
    send_point(make_point(OP_CART, -8388608, -8388608, 0, 0));
    send_point(make_point(OP_CART, -8388608, 0, 0, 0));
    send_point(make_point(OP_CART, 0, -8388608, 0, 0));
    drain_pipe();
  endtask

  task automatic test_line_patterns();
    cfg_t c;
    c.phi_center = '0;
    c.phi_half_width = ANGLE_W'(8192);
    c.left_slope = 32'sd65536;
    c.left_offset = 32'sd256000;
    c.right_slope = 32'sd32768;
    c.right_offset = 32'sd0;
    program_wedge(c);
    send_point(make_point(OP_CYL, 128000, 0, 8192, 0));
    send_point(make_point(OP_CYL, 512000, 0, 8193, 0));
    drain_pipe();
    c.left_slope = -32'sd65536;
    c.left_offset = 32'sd0;
    c.right_slope = 32'sd65536;
    program_wedge(c);
    send_point(make_point(OP_CYL, 384000, 0, -8192, 256000));
    send_point(make_point(OP_CYL, 128000, 0, 0, 256000));
    drain_pipe();
    c.left_slope = 32'sd0;
    c.left_offset = 32'sd25600;
    c.right_slope = 32'sd0;
    c.right_offset = 32'sd768000;
    c.phi_half_width = '0;
    program_wedge(c);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_point(make_point(OP_CYL, 128000, 0, 0, 1000));
    send_point(make_point(OP_CART, 128000, 0, 0, 1000));
    send_point(make_point(OP_CYL, 128000, 0, 1, 1000));
    drain_pipe();
  endtask

  task automatic run_points(int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_point(pick_point());
    drain_pipe();
  endtask

  task automatic test_extreme_wedges();
    cfg_t c;
    c = '{phi_center: 16'sh8000, phi_half_width: 16'h0000,
          left_slope: 32'h80000000, left_offset: 32'h7FFFFFFF,
          right_slope: 32'h7FFFFFFF, right_offset: 32'h80000000};
    program_wedge(c);
    run_points(60);
    c = '{phi_center: 16'sh7FFF, phi_half_width: HALF_WIDTH_RST,
          left_slope: 32'h7FFFFFFF, left_offset: 32'h7FFFFFFF,
          right_slope: 32'h00000001, right_offset: 32'h80000000};
    program_wedge(c);
    run_points(60);
    c = '{phi_center: 16'sh0000, phi_half_width: 16'h7FFF,
          left_slope: 32'hFFFFFFFF, left_offset: 32'h80000000,
          right_slope: 32'h7FFFFFFF, right_offset: 32'h7FFFFFFF};
    program_wedge(c);
    run_points(60);
    c = '{phi_center: ANGLE_W'($urandom), phi_half_width: 16'h0001,
          left_slope: 32'h0, left_offset: 32'h80000000,
          right_slope: 32'h0, right_offset: 32'h7FFFFFFF};
    program_wedge(c);
    run_points(60);
  endtask

  task automatic test_random_wedges();
    int unsigned n;
    for (n = 0; n < 12; n++) begin
      program_wedge(pick_wedge());
      run_points(100);
    end
  endtask

  task automatic test_back_to_back();
    program_wedge(pick_wedge());
    calm = 1'b1;
    run_points(200);
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    hit_valid = 1'b0;
    hit = '0;
    res_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    errors = 0;
    results_seen = 0;
    stuck_cycles = 0;
    wedge = '0;
    wedge.phi_half_width = HALF_WIDTH_RST;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_radius_limits();
    test_cartesian_quadrants();
    test_line_patterns();
    test_extreme_wedges();
    test_random_wedges();
    test_back_to_back();
    drain_pipe();
    if (pending_verdicts.size() != 0) errors += pending_verdicts.size();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
